// ----- design/vwd_pkg.sv -----
package vwd_pkg;

	// fixed widths of the vertex and result words
	localparam int FIELD_W   = 32;
	localparam int NUM_COMP  = 8;
	localparam int TOL_W     = 31;
	localparam int INDEX_W   = 8;
	localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} vwd_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture accepted vertex, restart the scan
		logic issue;      // read next table entry
		logic take_hit;   // latch matching index as result
		logic take_miss;  // append vertex or flag table full
		logic emit;       // move result into the output register
	} vwd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic more;       // entries left to read
		logic hit;        // compared entry lies within tolerance
		logic miss;       // scan finished without a match
		logic out_free;   // output register can take a word
	} vwd_status_t;

endpackage

// ----- design/vwd_if.sv -----
interface vwd_vertex_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  start_mesh;
	logic signed [vwd_pkg::FIELD_W-1:0]    pos_x;
	logic signed [vwd_pkg::FIELD_W-1:0]    pos_y;
	logic signed [vwd_pkg::FIELD_W-1:0]    pos_z;
	logic signed [vwd_pkg::FIELD_W-1:0]    norm_x;
	logic signed [vwd_pkg::FIELD_W-1:0]    norm_y;
	logic signed [vwd_pkg::FIELD_W-1:0]    norm_z;
	logic signed [vwd_pkg::FIELD_W-1:0]    tex_u;
	logic signed [vwd_pkg::FIELD_W-1:0]    tex_v;

	modport source (
		output valid, start_mesh, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
		input  ready
	);
	modport sink (
		input  valid, start_mesh, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
		output ready
	);
endinterface

interface vwd_result_if;
	logic                          valid;
	logic                          ready;
	logic [vwd_pkg::INDEX_W-1:0]   unique_index;
	logic                          is_new;
	logic                          table_full;

	modport source (
		output valid, unique_index, is_new, table_full,
		input  ready
	);
	modport sink (
		input  valid, unique_index, is_new, table_full,
		output ready
	);
endinterface

// ----- design/vertex_weld_dedup.sv -----
// Vertex welding with a per-component tolerance.
// vertex (sink): one expanded vertex per word, eight signed Q16.16 values
//   and a start_mesh flag that empties the unique-vertex table first.
// result (source): unique_index of the matching or appended entry, is_new
//   when appended, table_full when nothing matched and no room was left.
// tol_we / tol_wdata: write the tolerance register (reset 66); write only
//   while no word is in flight.
// The table is scanned from entry 0 upward, one entry per cycle through a
// registered memory read and a registered difference stage. A miss is
// reported once the last stored entry has left the difference stage, or at
// once when the table is empty; a match is reported when the matching entry
// leaves it, so the lowest matching entry wins. One word is handled at a
// time; the next is accepted once the result has moved into the output
// register.
// The result sits in an output register, so the next vertex is accepted while
// an earlier result still waits; a stalled receiver holds the result and at
// most one further finished result is held inside before the input blocks.
// Reset empties the table and restores the tolerance; table contents are
// not cleared and need no clearing pass.
module vertex_weld_dedup #(
	parameter int TABLE_DEPTH = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	vwd_vertex_if.sink                 vertex,
	vwd_result_if.source               result,
	input  logic                       tol_we,
	input  logic [vwd_pkg::TOL_W-1:0]  tol_wdata
);

	vwd_pkg::vwd_cmd_t    cmd;
	vwd_pkg::vwd_status_t st;

	// sequencer
	vwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vertex.valid),
		.in_ready (vertex.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// table, compare pipeline and output register
	vwd_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.tol_we       (tol_we),
		.tol_wdata    (tol_wdata),
		.start_mesh   (vertex.start_mesh),
		.pos_x        (vertex.pos_x),
		.pos_y        (vertex.pos_y),
		.pos_z        (vertex.pos_z),
		.norm_x       (vertex.norm_x),
		.norm_y       (vertex.norm_y),
		.norm_z       (vertex.norm_z),
		.tex_u        (vertex.tex_u),
		.tex_v        (vertex.tex_v),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.unique_index (result.unique_index),
		.is_new       (result.is_new),
		.table_full   (result.table_full)
	);

endmodule

// ----- design/vwd_ctrl.sv -----
module vwd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vwd_pkg::vwd_status_t st,
	output vwd_pkg::vwd_cmd_t    cmd
);

	vwd_pkg::vwd_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vwd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			vwd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = vwd_pkg::ST_SEARCH;
				end
			end
			vwd_pkg::ST_SEARCH: begin
				cmd.issue = st.more;
				if (st.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = vwd_pkg::ST_DONE;
				end else if (st.miss) begin
					cmd.take_miss = 1'b1;
					state_d       = vwd_pkg::ST_DONE;
				end
			end
			vwd_pkg::ST_DONE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = vwd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vwd_pkg::ST_IDLE;
			end
		endcase
	end

	// an accepted word always starts a scan
	a_load_to_search: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == vwd_pkg::ST_SEARCH)
		else $error("accepted word did not start a scan");

	// a result is only moved out when the output register has room
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result emitted into a full output register");

endmodule

// ----- design/vwd_datapath.sv -----
module vwd_datapath #(
	parameter int TABLE_DEPTH = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vwd_pkg::vwd_cmd_t                   cmd,
	output vwd_pkg::vwd_status_t                st,
	input  logic                                tol_we,
	input  logic [vwd_pkg::TOL_W-1:0]           tol_wdata,
	input  logic                                start_mesh,
	input  logic signed [vwd_pkg::FIELD_W-1:0]  pos_x,
	input  logic signed [vwd_pkg::FIELD_W-1:0]  pos_y,
	input  logic signed [vwd_pkg::FIELD_W-1:0]  pos_z,
	input  logic signed [vwd_pkg::FIELD_W-1:0]  norm_x,
	input  logic signed [vwd_pkg::FIELD_W-1:0]  norm_y,
	input  logic signed [vwd_pkg::FIELD_W-1:0]  norm_z,
	input  logic signed [vwd_pkg::FIELD_W-1:0]  tex_u,
	input  logic signed [vwd_pkg::FIELD_W-1:0]  tex_v,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [vwd_pkg::INDEX_W-1:0]         unique_index,
	output logic                                is_new,
	output logic                                table_full
);

	localparam int NC      = vwd_pkg::NUM_COMP;
	localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW      = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W = NC * VALUE_WIDTH;
	localparam int CMP_W   = (VALUE_WIDTH > vwd_pkg::TOL_W) ? VALUE_WIDTH : vwd_pkg::TOL_W;
	localparam int IW      = vwd_pkg::INDEX_W;

	logic [VALUE_WIDTH-1:0] in_vals [NC];
	logic [VALUE_WIDTH-1:0] vals_q  [NC];
	logic [ENTRY_W-1:0]     entry_c;
	logic [ENTRY_W-1:0]     table_q [TABLE_DEPTH];

	logic [vwd_pkg::TOL_W-1:0] tol_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             rd_addr_q;

	logic [ENTRY_W-1:0]     data_s1;
	logic                   valid_s1;
	logic [AW-1:0]          idx_s1;
	logic [VALUE_WIDTH-1:0] absdiff_s2 [NC];
	logic                   valid_s2;
	logic [AW-1:0]          idx_s2;

	logic [VALUE_WIDTH:0]   diff_c [NC];
	logic [VALUE_WIDTH:0]   mag_c  [NC];
	logic [NC-1:0]          within_c;
	logic                   hit_c;
	logic                   last_c;
	logic                   full_c;

	logic [IW-1:0]          res_index_q;
	logic                   res_new_q;
	logic                   res_full_q;
	logic                   out_valid_q;

	// take the low value bits of each field
	always_comb begin
		in_vals[0] = pos_x[VALUE_WIDTH-1:0];
		in_vals[1] = pos_y[VALUE_WIDTH-1:0];
		in_vals[2] = pos_z[VALUE_WIDTH-1:0];
		in_vals[3] = norm_x[VALUE_WIDTH-1:0];
		in_vals[4] = norm_y[VALUE_WIDTH-1:0];
		in_vals[5] = norm_z[VALUE_WIDTH-1:0];
		in_vals[6] = tex_u[VALUE_WIDTH-1:0];
		in_vals[7] = tex_v[VALUE_WIDTH-1:0];
		for (int k = 0; k < NC; k++) begin
			entry_c[k*VALUE_WIDTH +: VALUE_WIDTH] = vals_q[k];
		end
	end

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= vwd_pkg::TOL_RESET;
		end else if (tol_we) begin
			tol_q <= tol_wdata;
		end
	end

	// hold the vertex under search
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < NC; k++) begin
				vals_q[k] <= in_vals[k];
			end
		end
	end

	// entry count and read address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_addr_q <= '0;
		end else begin
			if (cmd.load) begin
				rd_addr_q <= '0;
				if (start_mesh) begin
					count_q <= '0;
				end
			end else begin
				if (cmd.issue) begin
					rd_addr_q <= rd_addr_q + CW'(1);
				end
				if (cmd.take_miss && !full_c) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// unique-vertex table: append on a miss, registered read during the scan
	always_ff @(posedge clk) begin
		if (cmd.take_miss && !full_c) begin
			table_q[count_q[AW-1:0]] <= entry_c;
		end
		if (cmd.issue) begin
			data_s1 <= table_q[rd_addr_q[AW-1:0]];
		end
		idx_s1 <= rd_addr_q[AW-1:0];
		idx_s2 <= idx_s1;
		for (int k = 0; k < NC; k++) begin
			absdiff_s2[k] <= mag_c[k][VALUE_WIDTH-1:0];
		end
	end

	// pipeline valid flags, dropped on a new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (cmd.load) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	// exact difference and magnitude per component
	always_comb begin
		for (int k = 0; k < NC; k++) begin
			diff_c[k] = {vals_q[k][VALUE_WIDTH-1], vals_q[k]}
				- {data_s1[k*VALUE_WIDTH + VALUE_WIDTH-1], data_s1[k*VALUE_WIDTH +: VALUE_WIDTH]};
			mag_c[k]  = diff_c[k][VALUE_WIDTH] ? (~diff_c[k] + 1'b1) : diff_c[k];
		end
	end

	// match and end-of-scan decisions
	always_comb begin
		for (int k = 0; k < NC; k++) begin
			within_c[k] = CMP_W'(absdiff_s2[k]) <= CMP_W'(tol_q);
		end
		hit_c       = valid_s2 && (&within_c);
		last_c      = valid_s2 && ((CW'(idx_s2) + CW'(1)) == count_q);
		full_c      = count_q == CW'(TABLE_DEPTH);
		st.more     = rd_addr_q < count_q;
		st.hit      = hit_c;
		st.miss     = (count_q == '0) || (last_c && !hit_c);
		st.out_free = !out_valid_q || out_ready;
	end

	// latch the result of the scan
	always_ff @(posedge clk) begin
		if (cmd.take_hit) begin
			res_index_q <= IW'(idx_s2);
			res_new_q   <= 1'b0;
			res_full_q  <= 1'b0;
		end else if (cmd.take_miss) begin
			res_index_q <= full_c ? '0 : IW'(count_q);
			res_new_q   <= !full_c;
			res_full_q  <= full_c;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique_index <= res_index_q;
			is_new       <= res_new_q;
			table_full   <= res_full_q;
		end
	end

	assign out_valid = out_valid_q;

	// an append grows the table by exactly one entry
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_miss && !full_c && !cmd.load |=> count_q == $past(count_q) + CW'(1))
		else $error("append did not advance the entry count");

	// a match always names a valid entry
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st.hit |-> CW'(idx_s2) < count_q)
		else $error("match on an entry beyond the count");

endmodule

// ----- verif/vertex_weld_dedup_tb.sv -----
module vertex_weld_dedup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WELD_DEPTH  = 256;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [vwd_pkg::TOL_W-1:0] TOL_MAX = {vwd_pkg::TOL_W{1'b1}};
	localparam logic [vwd_pkg::FIELD_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [vwd_pkg::FIELD_W-1:0] VAL_MIN = 32'h8000_0000;

	typedef logic [vwd_pkg::TOL_W-1:0] tol_t;

	// component order: pos x/y/z, norm x/y/z, tex u/v, pos_x in the low slot
	typedef logic [vwd_pkg::NUM_COMP-1:0][vwd_pkg::FIELD_W-1:0] vertex_vals_t;

	typedef struct packed {
		logic         start;
		vertex_vals_t vals;
	} vertex_t;

	typedef struct packed {
		logic [vwd_pkg::INDEX_W-1:0] idx;
		logic                        is_new;
		logic                        full;
	} weld_t;

	typedef struct packed {
		logic  given;
		weld_t want;
	} typed_weld_t;

	typedef struct packed {
		logic                      set_tol;
		logic [vwd_pkg::TOL_W-1:0] tol;
		vertex_t                   vtx;
		typed_weld_t               check;
	} vertex_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       tol_we;
	logic [vwd_pkg::TOL_W-1:0]  tol_wdata;

	vwd_vertex_if vtx_ch ();
	vwd_result_if res_ch ();

	vertex_weld_dedup #(
		.TABLE_DEPTH (WELD_DEPTH),
		.VALUE_WIDTH (vwd_pkg::FIELD_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.vertex    (vtx_ch),
		.result    (res_ch),
		.tol_we    (tol_we),
		.tol_wdata (tol_wdata)
	);

	// shadow of the unique-vertex table and tolerance
	vertex_vals_t               welded [WELD_DEPTH];
	int                         welded_count;
	logic [vwd_pkg::TOL_W-1:0]  weld_tol;

	weld_t             pending_welds [$];
	typed_weld_t       typed_welds [$];
	vertex_row_t       vertex_rows [$];
	vertex_vals_t      mesh_pool [$];
	int                weld_errors;
	int                results_seen;
	int                burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// search the shadow table, append on a miss
	function automatic weld_t weld_lookup(vertex_t v);
		weld_t  r;
		longint d;
		bit     close;
		bit     found;
		int     i;
		int     k;
		if (v.start)
			welded_count = 0;
		r = '0;
		found = 1'b0;
		for (i = 0; i < welded_count && !found; i++) begin
			close = 1'b1;
			for (k = 0; k < vwd_pkg::NUM_COMP; k++) begin
				d = longint'($signed(v.vals[k])) - longint'($signed(welded[i][k]));
				if (d < 0)
					d = -d;
				if (d > longint'(weld_tol))
					close = 1'b0;
			end
			if (close) begin
				r.idx = i[vwd_pkg::INDEX_W-1:0];
				found = 1'b1;
			end
		end
		if (!found) begin
			if (welded_count >= WELD_DEPTH) begin
				r.full = 1'b1;
			end else begin
				welded[welded_count] = v.vals;
				r.idx = welded_count[vwd_pkg::INDEX_W-1:0];
				r.is_new = 1'b1;
				welded_count++;
			end
		end
		return r;
	endfunction

	function automatic vertex_vals_t random_vals(bit wide_only);
		vertex_vals_t c;
		int           k;
		for (k = 0; k < vwd_pkg::NUM_COMP; k++) begin
			if (wide_only) begin
				c[k] = $urandom();
			end else begin
				case ($urandom_range(0, 9)) inside
					0, 1: c[k] = $urandom_range(0, 200) - 100;
					2: begin
						case ($urandom_range(0, 3))
							0: c[k] = VAL_MAX;
							1: c[k] = VAL_MIN;
							2: c[k] = '0;
							default: c[k] = '1;
						endcase
					end
					default: c[k] = $urandom();
				endcase
			end
		end
		return c;
	endfunction

	// move each component within the tolerance, or one component just past it
	function automatic vertex_vals_t nudge_vals(vertex_vals_t base,
			logic [vwd_pkg::TOL_W-1:0] tol, bit over);
		vertex_vals_t c;
		longint       mag;
		int           bad;
		int           k;
		bad = over ? int'($urandom_range(0, vwd_pkg::NUM_COMP - 1)) : -1;
		for (k = 0; k < vwd_pkg::NUM_COMP; k++) begin
			if (k == bad) begin
				mag = longint'(tol) + 1;
			end else begin
				case ($urandom_range(0, 2))
					0: mag = 0;
					1: mag = longint'(tol);
					default: mag = longint'($urandom_range(0, tol));
				endcase
			end
			if ($urandom_range(0, 1))
				mag = -mag;
			c[k] = base[k] + mag[vwd_pkg::FIELD_W-1:0];
		end
		return c;
	endfunction

	task automatic report_weld(string what);
		$display("[%0t] result %0d: %s", $time, results_seen, what);
		weld_errors++;
	endtask

	// accepted words on both channels
	always @(posedge clk) begin : watch_words
		vertex_t     v;
		weld_t       got;
		weld_t       want;
		typed_weld_t typed;
		if (arst_n) begin
			if (vtx_ch.valid && vtx_ch.ready) begin
				v.start   = vtx_ch.start_mesh;
				v.vals[0] = vtx_ch.pos_x;
				v.vals[1] = vtx_ch.pos_y;
				v.vals[2] = vtx_ch.pos_z;
				v.vals[3] = vtx_ch.norm_x;
				v.vals[4] = vtx_ch.norm_y;
				v.vals[5] = vtx_ch.norm_z;
				v.vals[6] = vtx_ch.tex_u;
				v.vals[7] = vtx_ch.tex_v;
				want = weld_lookup(v);
				typed = (typed_welds.size() != 0) ? typed_welds.pop_front() : '0;
				pending_welds.insert(pending_welds.size(), typed.given ? typed.want : want);
			end
			if (res_ch.valid && res_ch.ready) begin
				got.idx    = res_ch.unique_index;
				got.is_new = res_ch.is_new;
				got.full   = res_ch.table_full;
				if (pending_welds.size() == 0) begin
					report_weld("result word with nothing pending");
				end else begin
					want = pending_welds.pop_front();
					if (got.idx !== want.idx || got.is_new !== want.is_new
							|| got.full !== want.full)
						report_weld($sformatf("index %0d new %b full %b, wanted %0d %b %b",
							got.idx, got.is_new, got.full, want.idx, want.is_new,
							want.full));
				end
				results_seen++;
			end
		end
	end

	// offer one vertex in bursts with random gaps, hold until accepted
	task automatic offer_vertex(vertex_t v, typed_weld_t check);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				vtx_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		typed_welds.insert(typed_welds.size(), check);
		vtx_ch.start_mesh = v.start;
		vtx_ch.pos_x      = v.vals[0];
		vtx_ch.pos_y      = v.vals[1];
		vtx_ch.pos_z      = v.vals[2];
		vtx_ch.norm_x     = v.vals[3];
		vtx_ch.norm_y     = v.vals[4];
		vtx_ch.norm_z     = v.vals[5];
		vtx_ch.tex_u      = v.vals[6];
		vtx_ch.tex_v      = v.vals[7];
		vtx_ch.valid      = 1'b1;
		do
			@(posedge clk);
		while (vtx_ch.ready !== 1'b1);
	endtask

	task automatic offer_plain(vertex_t v);
		offer_vertex(v, '0);
	endtask

	// drop valid and wait until every result word has come back
	task automatic drain_welds();
		@(negedge clk);
		vtx_ch.valid = 1'b0;
		while (pending_welds.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_tolerance(logic [vwd_pkg::TOL_W-1:0] tol);
		drain_welds();
		repeat (4) @(negedge clk);
		tol_we    = 1'b1;
		tol_wdata = tol;
		@(negedge clk);
		tol_we    = 1'b0;
		weld_tol  = tol;
	endtask

	task automatic add_row(bit set_tol, logic [vwd_pkg::TOL_W-1:0] tol, bit start,
			vertex_vals_t vals, bit given = 1'b0, int idx = 0, bit is_new = 1'b0,
			bit full = 1'b0);
		vertex_row_t row;
		row.set_tol            = set_tol;
		row.tol                = tol;
		row.vtx.start          = start;
		row.vtx.vals           = vals;
		row.check.given        = given;
		row.check.want.idx     = idx[vwd_pkg::INDEX_W-1:0];
		row.check.want.is_new  = is_new;
		row.check.want.full    = full;
		vertex_rows.insert(vertex_rows.size(), row);
	endtask

	// whole mesh fill at zero tolerance, then matches and misses on a full table
	task automatic fill_table();
		vertex_t v;
		int      n;
		set_tolerance('0);
		mesh_pool.delete();
		for (n = 0; n < WELD_DEPTH; n++) begin
			v.start = (n == 0);
			v.vals  = random_vals(1'b1);
			mesh_pool.insert(mesh_pool.size(), v.vals);
			offer_plain(v);
			if ($urandom_range(0, 9) == 0) begin
				v.start = 1'b0;
				v.vals  = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
				offer_plain(v);
			end
		end
		for (n = 0; n < 16; n++) begin
			v.start = 1'b0;
			case ($urandom_range(0, 2))
				0: v.vals = random_vals(1'b1);
				1: v.vals = mesh_pool[mesh_pool.size() - 1];
				default: v.vals = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
			endcase
			offer_plain(v);
		end
	endtask

	// short meshes: fresh vertices, near copies, near misses and some noise
	task automatic run_meshes(logic [vwd_pkg::TOL_W-1:0] tol, int items);
		vertex_t      v;
		vertex_vals_t base;
		int           sent;
		int           left;
		int           roll;
		set_tolerance(tol);
		sent = 0;
		while (sent < items) begin
			left = $urandom_range(1, 25);
			mesh_pool.delete();
			while (left > 0 && sent < items) begin
				roll = $urandom_range(0, 9);
				v.start = (mesh_pool.size() == 0);
				if (mesh_pool.size() == 0 || roll < 4) begin
					v.vals = random_vals(1'b0);
					mesh_pool.insert(mesh_pool.size(), v.vals);
				end else begin
					base = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
					case (roll) inside
						4, 5, 6: v.vals = nudge_vals(base, tol, 1'b0);
						7: v.vals = nudge_vals(base, tol, 1'b1);
						8: v.vals = base;
						default: begin
							v.start = ($urandom_range(0, 3) == 0);
							v.vals  = random_vals(1'b0);
						end
					endcase
				end
				offer_plain(v);
				left--;
				sent++;
			end
		end
	endtask

	// receiver stall pattern, with two long hold-offs
	initial begin : result_drain
		int mode;
		int cyc;
		int holds;
		res_ch.ready = 1'b0;
		mode  = 0;
		cyc   = 0;
		holds = 0;
		forever begin
			@(negedge clk);
			if (holds < 2 && results_seen >= 60 + 340 * holds) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds++;
			end
			if (cyc % 48 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: res_ch.ready = 1'b1;
				1: res_ch.ready = ($urandom_range(0, 1) != 0);
				2: res_ch.ready = (cyc % 5) != 0;
				default: res_ch.ready = ($urandom_range(0, 7) == 0);
			endcase
			cyc++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("vertex_weld_dedup: mismatch");
		$finish;
	end

	initial begin : stimulus
		int r;
		arst_n            = 1'b0;
		tol_we            = 1'b0;
		tol_wdata         = '0;
		vtx_ch.valid      = 1'b0;
		vtx_ch.start_mesh = 1'b0;
		vtx_ch.pos_x      = '0;
		vtx_ch.pos_y      = '0;
		vtx_ch.pos_z      = '0;
		vtx_ch.norm_x     = '0;
		vtx_ch.norm_y     = '0;
		vtx_ch.norm_z     = '0;
		vtx_ch.tex_u      = '0;
		vtx_ch.tex_v      = '0;
		welded_count      = 0;
		weld_tol          = vwd_pkg::TOL_RESET;
		weld_errors       = 0;
		results_seen      = 0;
		burst_left        = 0;

		// reset tolerance: exact boundary, extremes, one component off
		add_row(0, 0, 1, '0, 1, 0, 1);
		add_row(0, 0, 0, {vwd_pkg::NUM_COMP{32'sd66}}, 1, 0, 0);
		add_row(0, 0, 0, {vwd_pkg::NUM_COMP{32'sd67}}, 1, 1, 1);
		add_row(0, 0, 0, {vwd_pkg::NUM_COMP{-32'sd66}}, 1, 0, 0);
		add_row(0, 0, 0, {vwd_pkg::NUM_COMP{VAL_MAX}}, 1, 2, 1);
		add_row(0, 0, 0, {vwd_pkg::NUM_COMP{VAL_MIN}}, 1, 3, 1);
		add_row(0, 0, 0, {vwd_pkg::NUM_COMP{VAL_MAX - 32'd66}}, 1, 2, 0);
		add_row(0, 0, 0, {vwd_pkg::NUM_COMP{VAL_MIN + 32'd66}}, 1, 3, 0);
		add_row(0, 0, 0, {{5{VAL_MIN}}, {3{VAL_MAX}}}, 1, 4, 1);
		add_row(0, 0, 0, {32'sd67, 224'd0}, 1, 5, 1);
		add_row(0, 0, 0, {32'sd66, 224'd0}, 1, 0, 0);
		add_row(0, 0, 0, {4{32'hAAAA_AAAA, 32'h5555_5555}});
		// start flag empties a partly filled table
		add_row(0, 0, 1, {vwd_pkg::NUM_COMP{32'sd67}}, 1, 0, 1);
		add_row(0, 0, 0, '0, 1, 1, 1);
		// zero tolerance: one lsb apart is a new vertex
		add_row(1, '0, 1, '0, 1, 0, 1);
		add_row(0, 0, 0, 256'd1, 1, 1, 1);
		add_row(0, 0, 0, '0, 1, 0, 0);
		// widest tolerance: differences span the full range without wrapping
		add_row(1, TOL_MAX, 1, {vwd_pkg::NUM_COMP{VAL_MIN}}, 1, 0, 1);
		add_row(0, 0, 0, '1, 1, 0, 0);
		add_row(0, 0, 0, '0, 1, 1, 1);
		add_row(0, 0, 0, {vwd_pkg::NUM_COMP{VAL_MAX}}, 1, 1, 0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (r = 0; r < vertex_rows.size(); r++) begin
			if (vertex_rows[r].set_tol)
				set_tolerance(vertex_rows[r].tol);
			offer_vertex(vertex_rows[r].vtx, vertex_rows[r].check);
		end

		fill_table();
		run_meshes(tol_t'($urandom_range(0, 1000)), 50);
		run_meshes(TOL_MAX, 50);
		run_meshes(tol_t'($urandom() & TOL_MAX), 50);
		run_meshes(vwd_pkg::TOL_RESET, 50);

		drain_welds();
		repeat (WELD_DEPTH + 8) @(posedge clk);
		if (weld_errors == 0)
			$display("vertex_weld_dedup: match");
		else
			$display("vertex_weld_dedup: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
design/vwd_pkg.sv
design/vwd_if.sv
design/vwd_ctrl.sv
design/vwd_datapath.sv
design/vertex_weld_dedup.sv
verif/vertex_weld_dedup_tb.sv
